@@ src/swarq_pkg.sv @@
// Shared types and constants for the sliding-window ARQ sender.
// Used by the register block, the sequencer and the top level.
package swarq_pkg;

    // Ring of frame lengths
    localparam int QUEUE_DEPTH = 16;
    localparam int QA_W        = $clog2(QUEUE_DEPTH);

    // Window limits and results per request
    localparam int MAX_WINDOW  = 8;
    localparam int MAX_RESULTS = 8;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    // Field widths
    localparam int SEQ_W  = 16;
    localparam int LEN_W  = 7;
    localparam int WIN_W  = 4;
    localparam int CMD_W  = 2;
    localparam int KIND_W = 2;

    // Special values
    localparam logic [SEQ_W-1:0] SEQ_RESTART    = SEQ_W'(1);
    localparam logic [SEQ_W-1:0] SEQ_LIMIT      = {SEQ_W{1'b1}};
    localparam logic [WIN_W-1:0] WINDOW_RESET   = WIN_W'(4);
    localparam logic [WIN_W-1:0] WINDOW_MIN     = WIN_W'(1);

    // Configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    typedef enum logic [0:0] {
        REG_WINDOW    = 1'b0,
        REG_SELECTIVE = 1'b1
    } t_reg;

    typedef enum logic [CMD_W-1:0] {
        CMD_SEND    = 2'd0,
        CMD_CTRL    = 2'd1,
        CMD_TIMEOUT = 2'd2
    } t_cmd;

    typedef enum logic [KIND_W-1:0] {
        KIND_DATA = 2'd0,
        KIND_ACK  = 2'd1,
        KIND_NAK  = 2'd2
    } t_kind;

    typedef struct packed {
        logic [WIN_W-1:0] window;
        logic             selective;
    } t_cfg;

endpackage

@@ src/swarq_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module swarq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        // read data holds until the next read
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ src/swarq_regs.sv @@
// APB-style configuration registers: window size and selective-repeat mode.
// Depends on swarq_pkg.
module swarq_regs
    import swarq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg r_cfg, n_cfg;
    t_reg w_reg;
    logic w_wr;

    assign w_reg  = t_reg'(paddr[APB_AW-1:2]);
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;

    // register write
    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (w_reg)
                REG_WINDOW:    n_cfg.window    = pwdata[WIN_W-1:0];
                REG_SELECTIVE: n_cfg.selective = pwdata[0];
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window    <= WINDOW_RESET;
            r_cfg.selective <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // read back
    always_comb begin
        unique case (w_reg)
            REG_WINDOW:    prdata = APB_DW'(r_cfg.window);
            REG_SELECTIVE: prdata = APB_DW'(r_cfg.selective);
            default:       prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

@@ src/swarq_ctrl.sv @@
// Window counters and transmit sequencer: decodes each request, updates the
// counters, reads stored lengths one per cycle unless the receiver stalls,
// fills the output register. Uses swarq_pkg; drives the swarq_ram length ring.
module swarq_ctrl
    import swarq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    // request side
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [CMD_W-1:0]  i_cmd,
    input  logic [SEQ_W-1:0]  i_seq,
    input  logic [SEQ_W-1:0]  i_ack,
    input  logic [KIND_W-1:0] i_kind,
    input  logic [LEN_W-1:0]  i_len,
    // length ring
    output logic              o_wr_en,
    output logic [QA_W-1:0]   o_wr_addr,
    output logic [LEN_W-1:0]  o_wr_data,
    output logic              o_rd_en,
    output logic [QA_W-1:0]   o_rd_addr,
    input  logic [LEN_W-1:0]  i_rd_data,
    // result side
    output logic              o_valid,
    input  logic              i_ready,
    output logic [SEQ_W-1:0]  o_frame,
    output logic [LEN_W-1:0]  o_len,
    output logic              o_last
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CHECK = 3'b010,
        S_LOAD  = 3'b100
    } t_state;

    typedef enum logic [1:0] {
        M_RELEASE = 2'd0,
        M_RANGE   = 2'd1,
        M_SINGLE  = 2'd2
    } t_mode;

    t_state r_state, n_state;
    t_mode  r_mode,  n_mode;
    logic [SEQ_W-1:0] r_base, n_base;
    logic [SEQ_W-1:0] r_sl,   n_sl;
    logic [SEQ_W-1:0] r_qe,   n_qe;
    logic [SEQ_W-1:0] r_cur,  n_cur;
    logic [CNT_W-1:0] r_cnt,  n_cnt;
    logic [SEQ_W-1:0] r_pframe, n_pframe;
    logic             r_ovalid, n_ovalid;
    logic [SEQ_W-1:0] r_oframe, n_oframe;
    logic [LEN_W-1:0] r_olen,   n_olen;
    logic             r_olast,  n_olast;

    logic             w_accept;
    logic             w_restart;
    logic [SEQ_W-1:0] w_a_base, w_a_sl, w_a_qe;
    logic             w_send_ok, w_ack_ok, w_nak_ok;
    logic [SEQ_W-1:0] w_nak_f;
    logic [SEQ_W-1:0] w_win;
    logic             w_more;
    logic [SEQ_W-1:0] w_next_frame;
    logic             w_load_ok;
    logic             w_issue;

    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid & o_ready;

    // effective window: zero acts as one, clamp at the maximum
    always_comb begin
        if (i_cfg.window < WINDOW_MIN) begin
            w_win = SEQ_W'(WINDOW_MIN);
        end else if (SEQ_W'(i_cfg.window) > SEQ_W'(MAX_WINDOW)) begin
            w_win = SEQ_W'(MAX_WINDOW);
        end else begin
            w_win = SEQ_W'(i_cfg.window);
        end
    end

    // request decode against current counters
    assign w_restart = (t_cmd'(i_cmd) == CMD_SEND) && (i_seq == SEQ_RESTART);
    assign w_a_base  = w_restart ? '0 : r_base;
    assign w_a_sl    = w_restart ? '0 : r_sl;
    assign w_a_qe    = w_restart ? '0 : r_qe;
    assign w_send_ok = ((w_a_qe - w_a_base) < SEQ_W'(QUEUE_DEPTH)) && (w_a_qe != SEQ_LIMIT);
    assign w_ack_ok  = (t_kind'(i_kind) == KIND_ACK) && (i_ack > r_base) && (i_ack <= r_sl);
    assign w_nak_f   = i_ack - SEQ_W'(1);
    assign w_nak_ok  = (t_kind'(i_kind) == KIND_NAK) && i_cfg.selective
                       && (w_nak_f >= r_base) && (w_nak_f < r_sl);

    // is there another frame to transmit for this request
    always_comb begin
        unique case (r_mode)
            M_RELEASE: w_more = (r_sl < r_qe) && ((r_sl - r_base) < w_win);
            M_RANGE:   w_more = (r_cur < r_sl);
            M_SINGLE:  w_more = (r_cnt == '0);
            default:   w_more = 1'b0;
        endcase
        w_more = w_more && (r_cnt < CNT_W'(MAX_RESULTS));
    end

    assign w_next_frame = (r_mode == M_RELEASE) ? r_sl : r_cur;
    assign w_load_ok    = (r_state == S_LOAD) && (!r_ovalid || i_ready);
    assign w_issue      = ((r_state == S_CHECK) || w_load_ok) && w_more;

    // ring ports: writes only at accept, reads only while sequencing
    assign o_wr_en   = w_accept && (t_cmd'(i_cmd) == CMD_SEND) && w_send_ok;
    assign o_wr_addr = w_a_qe[QA_W-1:0];
    assign o_wr_data = i_len;
    assign o_rd_en   = w_issue;
    assign o_rd_addr = w_next_frame[QA_W-1:0];

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_mode   = r_mode;
        n_base   = r_base;
        n_sl     = r_sl;
        n_qe     = r_qe;
        n_cur    = r_cur;
        n_cnt    = r_cnt;
        n_pframe = r_pframe;
        n_ovalid = r_ovalid;
        n_oframe = r_oframe;
        n_olen   = r_olen;
        n_olast  = r_olast;

        // result taken
        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_cnt = '0;
                    unique case (t_cmd'(i_cmd))
                        CMD_SEND: begin
                            n_base = w_a_base;
                            n_sl   = w_a_sl;
                            n_qe   = w_a_qe;
                            if (w_send_ok) begin
                                n_qe    = w_a_qe + SEQ_W'(1);
                                n_mode  = M_RELEASE;
                                n_state = S_CHECK;
                            end
                        end
                        CMD_CTRL: begin
                            if (w_ack_ok) begin
                                n_base  = i_ack;
                                n_mode  = M_RELEASE;
                                n_state = S_CHECK;
                            end else if (w_nak_ok) begin
                                n_cur   = w_nak_f;
                                n_mode  = M_SINGLE;
                                n_state = S_CHECK;
                            end
                        end
                        CMD_TIMEOUT: begin
                            if (!i_cfg.selective) begin
                                n_cur   = r_base;
                                n_mode  = M_RANGE;
                                n_state = S_CHECK;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_CHECK: begin
                n_state = w_more ? S_LOAD : S_IDLE;
            end
            S_LOAD: begin
                if (w_load_ok) begin
                    n_ovalid = 1'b1;
                    n_oframe = r_pframe;
                    n_olen   = i_rd_data;
                    n_olast  = !w_more;
                    n_state  = w_more ? S_LOAD : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // a read was issued: advance the frame pointer
        if (w_issue) begin
            n_pframe = w_next_frame;
            n_cnt    = r_cnt + CNT_W'(1);
            if (r_mode == M_RELEASE) begin
                n_sl = r_sl + SEQ_W'(1);
            end else begin
                n_cur = r_cur + SEQ_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mode   <= M_RELEASE;
            r_base   <= '0;
            r_sl     <= '0;
            r_qe     <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_mode   <= n_mode;
            r_base   <= n_base;
            r_sl     <= n_sl;
            r_qe     <= n_qe;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_cur    <= n_cur;
        r_pframe <= n_pframe;
        r_oframe <= n_oframe;
        r_olen   <= n_olen;
        r_olast  <= n_olast;
    end

    assign o_valid = r_ovalid;
    assign o_frame = r_oframe;
    assign o_len   = r_olen;
    assign o_last  = r_olast;

    // counters keep their order
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_base <= r_sl) && (r_sl <= r_qe))
        else $error("window counters out of order");

    // never more frames queued than the ring holds
    a_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_qe - r_base) <= SEQ_W'(QUEUE_DEPTH))
        else $error("length ring overfilled");

    // result count per request stays bounded
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_RESULTS))
        else $error("too many results for one request");

    // the load stage always follows a read
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |-> $past(w_issue) || $past(r_state == S_LOAD))
        else $error("load without a pending read");

    // no ring write while a request is being sequenced
    a_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |-> (r_state == S_IDLE) && !o_rd_en)
        else $error("ring write overlaps sequencing");

endmodule

@@ src/sliding_window_arq_sender_top.sv @@
// Sliding-window ARQ sender: top level with stream ports and APB config port.
// Depends on swarq_pkg, swarq_ram, swarq_regs and swarq_ctrl.
//
// Usage:
//   Requests enter on the s_axis channel: tuser carries the command (send,
//   received control frame, timeout) and the received frame kind; tdata
//   carries sequence number, ack/NAK number and frame length. Each request
//   yields zero to eight results on m_axis, each the number of a frame to
//   transmit and its stored length; tlast marks the final one for a request.
//   The first result passes the check state and a read of the length ring
//   before it reaches the output register; further results follow one per
//   cycle while the receiver takes them. A request yields at most 8 results
//   and reads the single read port of the length ring once per result.
//   A request that yields no result stays idle or passes only the check state.
//   The next request is taken while the last result still waits in the
//   output register. A stalled receiver holds the output register and
//   pauses the ring reads; nothing is lost.
//   Reset clears the three window counters, sets window 4 and go-back-N;
//   the ring contents are left as they are (only queued frames are read).
//   Configure window_size at 0x0 and selective_mode at 0x4 while idle.
module sliding_window_arq_sender_top
    import swarq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // config port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    // request stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [39:0]       s_axis_tdata,  // seq_number, ack_number, frame_length, pad
    input  logic [3:0]        s_axis_tuser,  // command, rx_kind
    // result stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [23:0]       m_axis_tdata,  // frame_number, tx_length, pad
    output logic              m_axis_tlast
);

    t_cfg             w_cfg;
    logic             w_wr_en;
    logic [QA_W-1:0]  w_wr_addr;
    logic [LEN_W-1:0] w_wr_data;
    logic             w_rd_en;
    logic [QA_W-1:0]  w_rd_addr;
    logic [LEN_W-1:0] w_rd_data;
    logic [SEQ_W-1:0] w_frame;
    logic [LEN_W-1:0] w_len;

    swarq_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // frame length ring
    swarq_ram #(
        .WIDTH (LEN_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    swarq_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_cmd     (s_axis_tuser[1:0]),
        .i_seq     (s_axis_tdata[15:0]),
        .i_ack     (s_axis_tdata[31:16]),
        .i_kind    (s_axis_tuser[3:2]),
        .i_len     (s_axis_tdata[38:32]),
        .o_wr_en   (w_wr_en),
        .o_wr_addr (w_wr_addr),
        .o_wr_data (w_wr_data),
        .o_rd_en   (w_rd_en),
        .o_rd_addr (w_rd_addr),
        .i_rd_data (w_rd_data),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_frame   (w_frame),
        .o_len     (w_len),
        .o_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, w_len, w_frame};

endmodule
